// ===== design/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg: shared types and constants for the star glob matcher
// Word formats, command codes, the neighbor link between cells, and defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgm_pkg;

  // Default pattern capacity in bytes.
  localparam int MAX_PATTERN_DEF = 64;

  // The only wildcard byte: '*'.
  localparam logic [7:0] STAR_BYTE = 8'h2A;

  // Command codes carried in each input word.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_VALUE  = 2'd2,
    CMD_END    = 2'd3
  } sgm_cmd_t;

  // Input word.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_in;
  } sgm_in_t;

  // Result word.
  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } sgm_out_t;

  // What one cell hands to the cell on its right.
  // link:  the closed active bit of a star position spills into the next position.
  // match: a literal position matched the current value byte.
  typedef struct packed {
    logic link;
    logic match;
  } sgm_link_t;

endpackage

// ===== design/star_glob_matcher.sv =====
// ----------------------------------------------------------------------------
// star_glob_matcher: whole-string matcher for patterns with '*' wildcards
// A result word appears in the cycle after its end command is taken.
// Throughput: one input word per cycle while no result word waits untaken;
// each word updates every cell at once through the row of position cells and the star closure ripple along it.
// Reset: empty pattern, overflow flag clear, only position zero active, no
// result pending. Pattern bytes are not cleared and are read only once written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module star_glob_matcher #(
  parameter int MAX_PATTERN = sgm_pkg::MAX_PATTERN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  sgm_pkg::sgm_in_t cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output sgm_pkg::sgm_out_t res
);
  import sgm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

  logic                   accept;
  logic [LEN_W-1:0]       length;
  logic                   overflow_seen;
  logic                   act_last;
  logic                   closed_last;
  logic                   matched;
  logic [MAX_PATTERN-1:0] hits;
  sgm_link_t              links [MAX_PATTERN+1];

  // A new word is taken whenever the result register is free or draining.
  assign cmd_ready = ~res_valid | res_ready;
  assign accept    = cmd_valid & cmd_ready;

  // Row of position cells, linked left to right.
  assign links[0] = '0;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    sgm_cell #(
      .IDX   (g),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .accept   (accept),
      .cmd      (cmd),
      .length   (length),
      .link_in  (links[g]),
      .link_out (links[g+1]),
      .hit      (hits[g])
    );
  end

  // The position just past a full pattern has no byte, only an active bit.
  assign closed_last = act_last | links[MAX_PATTERN].link;
  assign matched     = (|hits) | (closed_last & (length == LEN_MAX));

  // Pattern length, overflow flag and the final active bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      length        <= '0;
      overflow_seen <= 1'b0;
      act_last      <= 1'b0;
    end else if (accept) begin
      unique case (cmd.command)
        CMD_CLEAR: begin
          length        <= '0;
          overflow_seen <= 1'b0;
          act_last      <= 1'b0;
        end
        CMD_APPEND: begin
          if (length < LEN_MAX) begin
            length <= length + 1'b1;
          end else begin
            overflow_seen <= 1'b1;
          end
          act_last <= 1'b0;
        end
        CMD_VALUE: begin
          act_last <= links[MAX_PATTERN].match;
        end
        default: begin
          act_last <= 1'b0;
        end
      endcase
    end
  end

  // Result register: loaded on an end command, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && cmd.command == CMD_END) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.command == CMD_END) begin
      res.matched          <= matched;
      res.pattern_overflow <= overflow_seen;
    end
  end

  // An end command always produces a result word in the next cycle.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_END) |=> res_valid)
    else $error("end command did not produce a result");

  // The pattern length never goes past the store capacity.
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_MAX)
    else $error("pattern length exceeds capacity");

  // A clear empties the pattern and drops the overflow flag.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_CLEAR) |=> (length == '0 && !overflow_seen))
    else $error("clear left pattern state behind");

  // An append into a full store flags overflow and keeps the length.
  a_full_append: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_APPEND && length == LEN_MAX)
      |=> (overflow_seen && length == LEN_MAX))
    else $error("append into full store not flagged");

endmodule

// ===== design/sgm_cell.sv =====
// ----------------------------------------------------------------------------
// sgm_cell: one pattern position of the star glob matcher
// Holds one pattern byte and the active bit of its position, closes stars
// coming from the left and hands link and match bits to its right neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgm_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  sgm_pkg::sgm_in_t   cmd,
  input  logic [LEN_W-1:0]   length,
  input  sgm_pkg::sgm_link_t link_in,
  output sgm_pkg::sgm_link_t link_out,
  output logic               hit
);
  import sgm_pkg::*;

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [7:0] pat_byte;
  logic       act;
  logic       in_pat;
  logic       is_star;
  logic       closed;

  // Position state after star closure from the left.
  assign in_pat  = (MY_IDX < length);
  assign is_star = (pat_byte == STAR_BYTE);
  assign closed  = act | link_in.link;

  // Hand-off to the right neighbor and the end-of-value probe.
  assign link_out.link  = closed & in_pat & is_star;
  assign link_out.match = closed & in_pat & ~is_star & (pat_byte == cmd.byte_in);
  assign hit            = closed & (length == MY_IDX);

  // Pattern byte is written when this cell is the next free position.
  always_ff @(posedge clk) begin
    if (accept && cmd.command == CMD_APPEND && length == MY_IDX) begin
      pat_byte <= cmd.byte_in;
    end
  end

  // Active bit: advance on a value byte, restart on every other command.
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= (IDX == 0);
    end else if (accept) begin
      if (cmd.command == CMD_VALUE) begin
        act <= (closed & in_pat & is_star) | link_in.match;
      end else begin
        act <= (IDX == 0);
      end
    end
  end

endmodule

// ===== tb/star_glob_matcher_test.sv =====
// ----------------------------------------------------------------------------
// star_glob_matcher_test: self-checking bench for the star glob matcher
// A short table of command words, then random pattern loads and values built
// mostly to match. A local matcher of active pattern positions predicts each
// result word, and both handshakes idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module star_glob_matcher_test;
  import sgm_pkg::*;

  localparam int MAX_PAT = MAX_PATTERN_DEF;
  localparam int WORD_BUDGET = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int TABLE_ROWS = 26;

  // One row of the directed table; want is used only when pinned is set.
  typedef struct packed {
    sgm_cmd_t op;
    logic [7:0] data;
    logic pinned;
    sgm_out_t want;
  } table_row_t;

  localparam table_row_t DIRECTED [TABLE_ROWS] = '{
    '{CMD_END,    8'h00, 1'b1, 2'b10},  // empty pattern, empty value
    '{CMD_VALUE,  8'h61, 1'b0, 2'b00},
    '{CMD_END,    8'hFF, 1'b1, 2'b00},  // empty pattern, one value byte
    '{CMD_APPEND, STAR_BYTE, 1'b0, 2'b00},
    '{CMD_APPEND, STAR_BYTE, 1'b0, 2'b00},
    '{CMD_END,    8'h55, 1'b1, 2'b10},  // all stars, empty value
    '{CMD_VALUE,  8'h71, 1'b0, 2'b00},
    '{CMD_APPEND, 8'h61, 1'b0, 2'b00},  // pattern change restarts the value
    '{CMD_VALUE,  8'h61, 1'b0, 2'b00},
    '{CMD_END,    8'h00, 1'b0, 2'b00},
    '{CMD_CLEAR,  8'hFF, 1'b0, 2'b00},
    '{CMD_APPEND, 8'hFF, 1'b0, 2'b00},
    '{CMD_APPEND, 8'h00, 1'b0, 2'b00},
    '{CMD_VALUE,  8'hFF, 1'b0, 2'b00},
    '{CMD_VALUE,  8'h00, 1'b0, 2'b00},
    '{CMD_END,    8'hFF, 1'b0, 2'b00},
    '{CMD_VALUE,  8'hFF, 1'b0, 2'b00},
    '{CMD_END,    8'h00, 1'b0, 2'b00},
    '{CMD_CLEAR,  8'h00, 1'b0, 2'b00},
    '{CMD_APPEND, 8'h61, 1'b0, 2'b00},
    '{CMD_APPEND, STAR_BYTE, 1'b0, 2'b00},
    '{CMD_APPEND, 8'h62, 1'b0, 2'b00},
    '{CMD_VALUE,  8'h61, 1'b0, 2'b00},
    '{CMD_VALUE,  STAR_BYTE, 1'b0, 2'b00},  // a literal star in the value
    '{CMD_VALUE,  8'h62, 1'b0, 2'b00},
    '{CMD_END,    8'h00, 1'b0, 2'b00}
  };

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  sgm_in_t cmd;
  logic res_valid;
  logic res_ready;
  sgm_out_t res;

  // Local copy of the matcher state.
  logic [7:0] pat_bytes [MAX_PAT];
  int unsigned pat_len;
  logic [MAX_PAT:0] live_pos;
  logic ovf_seen;

  sgm_out_t awaited_results [$];
  int mismatches;
  int words_sent;
  int cycles;
  bit idle_on;

  star_glob_matcher #(.MAX_PATTERN(MAX_PAT)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // A star at an active position also activates the position after it.
  function automatic void close_star_positions();
    for (int unsigned p = 0; p < pat_len; p++) begin
      if (live_pos[p] && pat_bytes[p] == STAR_BYTE) live_pos[p + 1] = 1'b1;
    end
  endfunction

  // Moves the active set across one value byte.
  function automatic void advance_positions(input logic [7:0] c);
    logic [MAX_PAT:0] nxt;
    nxt = '0;
    close_star_positions();
    for (int unsigned p = 0; p < pat_len; p++) begin
      if (live_pos[p]) begin
        if (pat_bytes[p] == STAR_BYTE) nxt[p] = 1'b1;
        else if (pat_bytes[p] == c) nxt[p + 1] = 1'b1;
      end
    end
    live_pos = nxt;
  endfunction

  // Applies one accepted word; returns 1 when it yields a result word.
  function automatic bit predict_match(input sgm_cmd_t op, input logic [7:0] data,
                                       output sgm_out_t outcome);
    outcome = '0;
    case (op)
      CMD_CLEAR: begin
        pat_len = 0;
        ovf_seen = 1'b0;
        live_pos = (MAX_PAT + 1)'(1);
        return 1'b0;
      end
      CMD_APPEND: begin
        if (pat_len < MAX_PAT) begin
          pat_bytes[pat_len] = data;
          pat_len++;
        end else begin
          ovf_seen = 1'b1;
        end
        live_pos = (MAX_PAT + 1)'(1);
        return 1'b0;
      end
      CMD_VALUE: begin
        advance_positions(data);
        return 1'b0;
      end
      default: begin
        close_star_positions();
        outcome.matched = live_pos[pat_len];
        outcome.pattern_overflow = ovf_seen;
        live_pos = (MAX_PAT + 1)'(1);
        return 1'b1;
      end
    endcase
  endfunction

  // Offers one word after a random gap and waits for it to be taken.
  task automatic send_word(input sgm_cmd_t op, input logic [7:0] data,
                           input logic pinned = 1'b0, input sgm_out_t want = '0);
    int gap;
    sgm_out_t outcome;
    if (words_sent % 128 == 0) idle_on = ($urandom_range(0, 3) != 0);
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= sgm_in_t'{op, data};
    do @(posedge clk); while (cmd_ready !== 1'b1);
    words_sent++;
    if (predict_match(op, data, outcome)) begin
      awaited_results.insert(awaited_results.size(), pinned ? want : outcome);
    end
  endtask

  // Pattern and value bytes lean on a small alphabet and the star.
  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 11);
    if (roll < 4) return STAR_BYTE;
    if (roll < 10) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom);
  endfunction

  // One pattern load followed by a few values, each closed by an end word.
  task automatic run_sequence(input bit force_long);
    int plen;
    int nvals;
    int mode;
    int idx;
    logic [7:0] text [$];
    if (force_long || $urandom_range(0, 3) != 0) send_word(CMD_CLEAR, 8'($urandom));
    if (force_long) plen = MAX_PAT + 3;
    else if ($urandom_range(0, 19) == 0) plen = $urandom_range(MAX_PAT - 4, MAX_PAT + 4);
    else plen = $urandom_range(0, 6);
    for (int i = 0; i < plen; i++) send_word(CMD_APPEND, pick_byte());
    nvals = $urandom_range(1, 4);
    for (int v = 0; v < nvals; v++) begin
      // Occasional stray word breaks the sequence.
      if ($urandom_range(0, 9) == 0) begin
        send_word(sgm_cmd_t'($urandom_range(0, 3)), 8'($urandom));
      end
      text.delete();
      mode = $urandom_range(0, 5);
      if (mode < 5) begin
        // Expand the current pattern, stars taking short random runs.
        for (int unsigned p = 0; p < pat_len; p++) begin
          if (pat_bytes[p] == STAR_BYTE) begin
            repeat ($urandom_range(0, 3)) text.insert(text.size(), pick_byte());
          end else begin
            text.insert(text.size(), pat_bytes[p]);
          end
        end
        if (mode >= 3 && text.size() > 0) begin
          idx = $urandom_range(0, text.size() - 1);
          if (mode == 3) text[idx] = text[idx] ^ (8'h01 << $urandom_range(0, 7));
          else text.delete(idx);
        end
      end else begin
        repeat ($urandom_range(0, 8)) text.insert(text.size(), pick_byte());
      end
      foreach (text[k]) send_word(CMD_VALUE, text[k]);
      send_word(CMD_END, 8'($urandom));
    end
  endtask

  // Result side: random stalls, then compare against the oldest prediction.
  initial begin
    int gap;
    sgm_out_t want;
    res_ready = 1'b0;
    forever begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!(rst === 1'b0 && res_valid === 1'b1));
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %b", $time, res);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (res.matched !== want.matched) begin
          $display("%0t: matched mismatch, expected %b, actual %b",
                   $time, want.matched, res.matched);
          mismatches++;
        end
        if (res.pattern_overflow !== want.pattern_overflow) begin
          $display("%0t: pattern_overflow mismatch, expected %b, actual %b",
                   $time, want.pattern_overflow, res.pattern_overflow);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random sequences, drain.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    cycles = 0;
    mismatches = 0;
    words_sent = 0;
    idle_on = 1'b0;
    pat_len = 0;
    ovf_seen = 1'b0;
    live_pos = (MAX_PAT + 1)'(1);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      send_word(DIRECTED[r].op, DIRECTED[r].data, DIRECTED[r].pinned, DIRECTED[r].want);
    end

    // The first sequence overfills the store; later ones mostly stay small.
    run_sequence(1'b1);
    while (words_sent < WORD_BUDGET) run_sequence(1'b0);
    cmd_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
